// ----- sv/asc_pkg.sv -----
// Shared types and constants for the accelerometer sample conditioner.
// No dependencies; imported by asc_scale and accel_sample_conditioner_core.
`default_nettype none

package asc_pkg;

    localparam int CODE_W      = 12;
    localparam int NUM_CHAN    = 4;
    localparam int CHAN_W      = 2;
    localparam int AVG_DEPTH_DEF = 16;

    localparam logic [CODE_W-1:0] FULL_SCALE = 12'd4095;

    // front-end scaling constants (gains are Q2.14)
    localparam logic [CODE_W-1:0] LX_OFFSET = 12'd497;
    localparam logic [CODE_W-1:0] Y_OFFSET  = 12'd1116;
    localparam logic [CODE_W-1:0] Y_FLOOR   = 12'd1217;
    localparam logic [15:0]       GAIN_RX   = 16'd37809;
    localparam logic [15:0]       GAIN_RY   = 16'd41590;
    localparam int                GAIN_FRAC = 14;

    // input codes
    localparam logic [1:0] HAND_LEFT  = 2'd0;
    localparam logic [1:0] HAND_RIGHT = 2'd1;
    localparam logic       AXIS_X     = 1'b0;

    // register indexes
    localparam logic [1:0] CFG_BAND_CENTER = 2'd0;
    localparam logic [1:0] CFG_BAND_HALF   = 2'd1;
    localparam logic [1:0] CFG_GATE_ON     = 2'd2;
    localparam logic [1:0] CFG_GATE_OFF    = 2'd3;

    // channel numbers: {right, y}
    localparam logic [CHAN_W-1:0] CH_LEFT_Y = 2'd1;

    typedef struct packed {
        logic              known;
        logic [CHAN_W-1:0] ch;
        logic [CODE_W-1:0] val;
    } asc_scaled_t;

endpackage

`default_nettype wire

// ----- sv/asc_scale.sv -----
// Front-end scaling: per hand/axis offset, gain and clamp to a 12-bit code.
// Depends on asc_pkg.
`default_nettype none

module asc_scale (
    input  wire logic [9:0]        raw_sample,
    input  wire logic              axis,
    input  wire logic [1:0]        hand,
    output asc_pkg::asc_scaled_t   scaled
);
    import asc_pkg::*;

    logic [CODE_W-1:0] v;
    logic [CODE_W-1:0] vf;
    logic [CODE_W-1:0] d_lx;
    logic [CODE_W-1:0] d_y;
    logic [CODE_W-1:0] d_rx;
    logic [CODE_W+1:0] lx_x2;
    logic [CODE_W+1:0] ly_x2;
    logic [27:0]       prod_rx;
    logic [27:0]       prod_ry;
    logic [CODE_W-1:0] val;

    function automatic logic [CODE_W-1:0] sat14(input logic [CODE_W+1:0] x);
        sat14 = (x > {2'b00, FULL_SCALE}) ? FULL_SCALE : x[CODE_W-1:0];
    endfunction

    always_comb begin
        v    = {raw_sample, 2'b00};
        vf   = (v < Y_FLOOR) ? Y_FLOOR : v;
        // negative differences clamp to zero before gain
        d_lx = (v < LX_OFFSET) ? '0 : v - LX_OFFSET;
        d_rx = (v < Y_OFFSET)  ? '0 : v - Y_OFFSET;
        d_y  = vf - Y_OFFSET;
        lx_x2   = {1'b0, d_lx, 1'b0};
        ly_x2   = {1'b0, d_y, 1'b0};
        prod_rx = 28'(d_rx) * 28'(GAIN_RX);
        prod_ry = 28'(d_y) * 28'(GAIN_RY);
        val = v;
        if (hand == HAND_LEFT) begin
            val = (axis == AXIS_X) ? sat14(lx_x2) : sat14(ly_x2);
        end else if (hand == HAND_RIGHT) begin
            val = (axis == AXIS_X) ? sat14(prod_rx[GAIN_FRAC +: CODE_W+2])
                                   : sat14(prod_ry[GAIN_FRAC +: CODE_W+2]);
        end
        scaled.known  = ~hand[1];
        scaled.ch     = {hand[0], axis};
        scaled.val    = val;
    end

endmodule

`default_nettype wire

// ----- sv/accel_sample_conditioner_core.sv -----
// Accelerometer sample conditioner: scaling, per-channel moving average,
// band pull, hysteresis gate and X inversion. Depends on asc_pkg, asc_scale.
//
// Usage: items enter on s_valid/s_ready (raw_sample, axis, hand) and leave on
// m_valid/m_ready (dac_code, out_axis), one result per item, in order.
// The accepted item passes through four register stages, the output
// register being the last; while the output is not stalled, throughput is
// one item per cycle. Stage 1 holds the history read (synchronous memory),
// stage 2 the running-sum update and history write-back, stage 3 the
// divide by AVG_DEPTH (reciprocal multiply), then band/gate/invert into the
// output register. Each stage only waits if the one after it is full, so
// bubbles collapse and the input keeps being taken while a result waits.
// Consecutive items of one channel use consecutive ring slots, so a read
// never meets a write of the same entry; the sum register is updated in
// the same stage that reads it.
// Reset: sums, ring positions, lap flags, gate and configuration return to
// defaults; history entries count as zero until their channel's ring has
// completed one lap, so no clearing pass is needed and items are accepted
// right after reset. A stalled receiver fills the four stages, then
// s_ready drops.
// Unknown-hand items pass through with no state change.
`default_nettype none

module accel_sample_conditioner_core #(
    parameter int AVG_DEPTH = asc_pkg::AVG_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [9:0]                  s_raw_sample,
    input  wire logic                        s_axis,
    input  wire logic [1:0]                  s_hand,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [asc_pkg::CODE_W-1:0]       m_dac_code,
    output logic                             m_out_axis,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [asc_pkg::CODE_W-1:0]  cfg_wdata
);
    import asc_pkg::*;

    localparam int SLW   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int AW    = CHAN_W + SLW;
    localparam int DEPTH = NUM_CHAN << SLW;
    localparam int SW    = CODE_W + SLW;
    localparam int MW    = SW + 1;
    localparam int RS    = SW + SLW;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RS) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
    localparam logic [MW-1:0]  RECIP_M  = MW'(RECIP_FULL);
    localparam logic [SLW-1:0] SLOT_LAST = SLW'(AVG_DEPTH - 1);

    // configuration
    logic [CODE_W-1:0] band_center_reg, band_half_reg, gate_on_reg, gate_off_reg;

    // channel state
    logic [SLW-1:0]    slot_reg [NUM_CHAN];
    logic [NUM_CHAN-1:0] full_reg;
    logic [SW-1:0]     sums_reg [NUM_CHAN];
    logic              gate_open_reg;
    logic              gate_open_next;

    // history memory
    logic [CODE_W-1:0] hist_mem [DEPTH];
    logic [CODE_W-1:0] hist_rdata_reg;

    // pipeline
    logic              v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic              en1, en2, en3, en_out, s_acc, mv1;
    asc_scaled_t       in_scaled;
    logic [AW-1:0]     rd_addr;

    logic [CODE_W-1:0] p1_val_reg;
    logic [CHAN_W-1:0] p1_ch_reg;
    logic              p1_tagged_reg, p1_axis_reg, p1_old_vld_reg;
    logic [AW-1:0]     p1_addr_reg;

    logic [SW-1:0]     p2_sum_reg;
    logic [CODE_W-1:0] p2_val_reg;
    logic [CHAN_W-1:0] p2_ch_reg;
    logic              p2_tagged_reg, p2_axis_reg;

    logic [CODE_W-1:0] p3_avg_reg;
    logic [CHAN_W-1:0] p3_ch_reg;
    logic              p3_tagged_reg, p3_axis_reg;

    logic [CODE_W-1:0] m_dac_code_reg;
    logic              m_out_axis_reg;

    logic [CODE_W-1:0] old_val;
    logic [SW-1:0]     sum_next;
    logic [SW+MW-1:0]  prod;
    logic [CODE_W-1:0] quot;

    logic [CODE_W:0]   band_hi;
    logic [CODE_W+1:0] band_lo;
    logic              in_band;
    logic [CODE_W-1:0] pulled;
    logic [CODE_W-1:0] code;

    asc_scale u_scale (
        .raw_sample (s_raw_sample),
        .axis       (s_axis),
        .hand       (s_hand),
        .scaled     (in_scaled)
    );

    // ready chain: a stage advances when it is empty or its successor moves
    assign en_out  = !m_valid_reg || m_ready;
    assign en3     = !v3_reg || en_out;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign s_acc   = s_valid && en1;
    assign mv1     = v1_reg && en2;
    assign rd_addr = {in_scaled.ch, slot_reg[in_scaled.ch]};

    assign m_valid    = m_valid_reg;
    assign m_dac_code = m_dac_code_reg;
    assign m_out_axis = m_out_axis_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_center_reg <= 12'd2047;
            band_half_reg   <= 12'd1300;
            gate_on_reg     <= 12'd1000;
            gate_off_reg    <= 12'd500;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BAND_CENTER: band_center_reg <= cfg_wdata;
                CFG_BAND_HALF:   band_half_reg   <= cfg_wdata;
                CFG_GATE_ON:     gate_on_reg     <= cfg_wdata;
                CFG_GATE_OFF:    gate_off_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // history memory: read at accept, write back when stage 1 moves on
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            hist_rdata_reg <= hist_mem[rd_addr];
        end
        if (mv1 && p1_tagged_reg) begin
            hist_mem[p1_addr_reg] <= p1_val_reg;
        end
    end

    always_comb begin
        old_val  = p1_old_vld_reg ? hist_rdata_reg : '0;
        sum_next = sums_reg[p1_ch_reg] - SW'(old_val) + SW'(p1_val_reg);
        prod     = (SW+MW)'(p2_sum_reg) * (SW+MW)'(RECIP_M);
        quot     = prod[RS +: CODE_W];
    end

    // channel state and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                slot_reg[i] <= '0;
                sums_reg[i] <= '0;
            end
            full_reg      <= '0;
            gate_open_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_acc && in_scaled.known) begin
                if (slot_reg[in_scaled.ch] == SLOT_LAST) begin
                    slot_reg[in_scaled.ch] <= '0;
                    full_reg[in_scaled.ch] <= 1'b1;
                end else begin
                    slot_reg[in_scaled.ch] <= slot_reg[in_scaled.ch] + SLW'(1);
                end
            end
            if (mv1 && p1_tagged_reg) begin
                sums_reg[p1_ch_reg] <= sum_next;
            end
            if (v3_reg && en_out) begin
                gate_open_reg <= gate_open_next;
            end
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en_out) m_valid_reg <= v3_reg;
        end
    end

    // band pull, gate and inversion for the last stage
    always_comb begin
        band_hi = {1'b0, band_center_reg} + {1'b0, band_half_reg};
        band_lo = {2'b00, band_center_reg} - {2'b00, band_half_reg};
        in_band = (band_hi > {1'b0, p3_avg_reg}) &&
                  ($signed(band_lo) < $signed({2'b00, p3_avg_reg}));
        if (p3_avg_reg > band_center_reg) begin
            pulled = band_center_reg + ((p3_avg_reg - band_center_reg) >> 2);
        end else begin
            pulled = band_center_reg - ((band_center_reg - p3_avg_reg) >> 2);
        end

        gate_open_next = gate_open_reg;
        if (p3_tagged_reg && p3_ch_reg == CH_LEFT_Y) begin
            if (p3_avg_reg >= gate_on_reg) begin
                gate_open_next = 1'b1;
            end else if (p3_avg_reg <= gate_off_reg) begin
                gate_open_next = 1'b0;
            end
        end

        code = p3_avg_reg;
        if (p3_tagged_reg && p3_ch_reg[1] && in_band) begin
            code = pulled;
        end
        if (p3_tagged_reg && p3_ch_reg == CH_LEFT_Y && !gate_open_next) begin
            code = '0;
        end
        if (p3_axis_reg == AXIS_X) begin
            code = FULL_SCALE - code;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en1) begin
            p1_val_reg     <= in_scaled.val;
            p1_ch_reg      <= in_scaled.ch;
            p1_tagged_reg  <= in_scaled.known;
            p1_axis_reg    <= s_axis;
            p1_old_vld_reg <= full_reg[in_scaled.ch];
            p1_addr_reg    <= rd_addr;
        end
        if (en2) begin
            p2_sum_reg    <= sum_next;
            p2_val_reg    <= p1_val_reg;
            p2_ch_reg     <= p1_ch_reg;
            p2_tagged_reg <= p1_tagged_reg;
            p2_axis_reg   <= p1_axis_reg;
        end
        if (en3) begin
            p3_avg_reg    <= p2_tagged_reg ? quot : p2_val_reg;
            p3_ch_reg     <= p2_ch_reg;
            p3_tagged_reg <= p2_tagged_reg;
            p3_axis_reg   <= p2_axis_reg;
        end
        if (en_out) begin
            m_dac_code_reg <= code;
            m_out_axis_reg <= p3_axis_reg;
        end
    end

    // a history write never lands on the entry being read in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && mv1 && p1_tagged_reg) |-> (rd_addr != p1_addr_reg))
        else $error("history read/write collision");

    // lap flags only ever set after reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((full_reg & $past(full_reg)) == $past(full_reg)))
        else $error("lap flag cleared");

    // gate only moves on a left Y item leaving the last stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(v3_reg && en_out && p3_tagged_reg && p3_ch_reg == CH_LEFT_Y)
        |=> $stable(gate_open_reg))
        else $error("gate changed without left Y item");

    // output register only loads from a valid last stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (en_out && !v3_reg) |=> !m_valid_reg)
        else $error("result without item");

endmodule

`default_nettype wire
